// ----- design/rra_pkg.sv -----
// ----------------------------------------------------------------------------
// rra_pkg: shared types, tables and round functions
// S-boxes, GF(2^8) helpers and the round transforms of the cipher cells.
// ----------------------------------------------------------------------------
`default_nettype none
package rra_pkg;

   localparam int RoundCountDefault = 2;
   localparam int BlockWidth        = 128;
   localparam int HalfWidth         = 64;
   localparam int CsrIndexWidth     = 1;

   localparam logic [CsrIndexWidth-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_LOW  = 1'b1;

   typedef logic [BlockWidth-1:0] block_type;
   typedef logic [7:0]            byte_type;

   typedef struct packed {
      logic      valid;
      logic      op;
      block_type data;
   } stage_type;

   function automatic byte_type sbox(input byte_type a);
      byte_type t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic byte_type sbox_inverse(input byte_type a);
      byte_type t [256];
      t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[a];
   endfunction

   function automatic byte_type xtime(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block sits in bits 127-8i downto 120-8i
   function automatic byte_type get_byte(input block_type b, input int i);
      return b[BlockWidth-1-8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      t = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[BlockWidth-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c+r)%4)));
      return t;
   endfunction

   function automatic block_type inv_sub_shift(input block_type s);
      block_type t;
      t = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[BlockWidth-1-8*(r+4*((c+r)%4)) -: 8] = sbox_inverse(get_byte(s, r + 4*c));
      return t;
   endfunction

   function automatic block_type mix(input block_type s, input logic inverse);
      block_type t;
      byte_type a0, a1, a2, a3, all, u, v, w;
      t = '0;
      for (int c = 0; c < 16; c += 4) begin
         a0 = get_byte(s, c); a1 = get_byte(s, c+1);
         a2 = get_byte(s, c+2); a3 = get_byte(s, c+3);
         all = a0 ^ a1 ^ a2 ^ a3;
         u = xtime(xtime(a0 ^ a2));
         v = xtime(xtime(a1 ^ a3));
         w = xtime(u ^ v);
         if (!inverse) begin
            u = '0; v = '0; w = '0;
         end
         t[BlockWidth-1-8*c     -: 8] = xtime(a0 ^ a1) ^ a0 ^ all ^ w ^ u;
         t[BlockWidth-1-8*(c+1) -: 8] = xtime(a1 ^ a2) ^ a1 ^ all ^ w ^ v;
         t[BlockWidth-1-8*(c+2) -: 8] = xtime(a2 ^ a3) ^ a2 ^ all ^ w ^ u;
         t[BlockWidth-1-8*(c+3) -: 8] = xtime(a3 ^ a0) ^ a3 ^ all ^ w ^ v;
      end
      return t;
   endfunction

   // one step of the standard key schedule
   function automatic block_type next_key(input block_type k, input byte_type rcon);
      block_type n;
      byte_type t0, t1, t2, t3;
      t0 = sbox(get_byte(k, 13)) ^ rcon;
      t1 = sbox(get_byte(k, 14));
      t2 = sbox(get_byte(k, 15));
      t3 = sbox(get_byte(k, 12));
      n[127:96] = k[127:96] ^ {t0, t1, t2, t3};
      n[95:64]  = k[95:64] ^ n[127:96];
      n[63:32]  = k[63:32] ^ n[95:64];
      n[31:0]   = k[31:0] ^ n[63:32];
      return n;
   endfunction

endpackage
`default_nettype wire

// ----- design/rra_if.sv -----
// ----------------------------------------------------------------------------
// rra_if: valid/ready channel interfaces
// Block channel, result channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface rra_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [63:0] block_high;
   logic [63:0] block_low;
   modport source (output valid, op, block_high, block_low, input ready);
   modport sink   (input valid, op, block_high, block_low, output ready);
endinterface

interface rra_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   modport source (output valid, result_high, result_low, input ready);
   modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface rra_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/rra_key_cell.sv -----
// ----------------------------------------------------------------------------
// rra_key_cell: one round key of the schedule
// Holds round key i and derives it from its left neighbour each cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rra_key_cell import rra_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire byte_type  rcon,
   input  wire block_type prev_key,
   output block_type      key
);
   block_type key_ff, key_in;
   logic      seeded_ff;

   // the chain settles one cell per cycle after a key write
   assign key_in = next_key(prev_key, rcon);

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
      end else begin
         seeded_ff <= 1'b1;
      end
      key_ff <= key_in;
   end

   assign key = seeded_ff ? key_ff : key_in;
endmodule
`default_nettype wire

// ----- design/rra_round_cell.sv -----
// ----------------------------------------------------------------------------
// rra_round_cell: one round of the cipher pipeline
// Applies one encrypt or decrypt round and hands the block to its neighbour.
// ----------------------------------------------------------------------------
`default_nettype none
module rra_round_cell import rra_pkg::*; #(
   parameter bit FIRST = 1'b0,
   parameter bit LAST  = 1'b0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire stage_type stage_in,
   input  wire block_type enc_key,
   input  wire block_type dec_key,
   output stage_type      stage_out
);
   stage_type stage_ff, stage_in_c;
   block_type enc, dec, dmix;

   // enc: sub/shift, mix unless last, add key
   // dec: add key, inverse mix unless first, inverse sub/shift
   always_comb begin
      enc  = sub_shift(stage_in.data);
      enc  = (LAST ? enc : mix(enc, 1'b0)) ^ enc_key;
      dmix = stage_in.data ^ dec_key;
      dec  = inv_sub_shift(FIRST ? dmix : mix(dmix, 1'b1));
      stage_in_c       = stage_in;
      stage_in_c.data  = stage_in.op ? dec : enc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_c.valid;
      end
      if (advance) begin
         stage_ff.op   <= stage_in_c.op;
         stage_ff.data <= stage_in_c.data;
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

// ----- design/reduced_round_aes128_cipher.sv -----
// ----------------------------------------------------------------------------
// reduced_round_aes128_cipher: reduced-round AES-128, ECB
// Unrolled round pipeline with a chained key schedule.
// ----------------------------------------------------------------------------
// One block enters per cycle while the pipeline advances and no key write or
// key settling holds ready low; its result reaches rsp through ROUND_COUNT+1
// registers (an input key-add register and one per round cell). The pipeline
// advances whenever its output register is empty or being taken. The round key
// chain re-derives one round key per cycle after a key write, so the block
// input holds ready low during a key write and until the settle counter has
// run down after it; blocks accepted after that see the new keys.
`default_nettype none
module reduced_round_aes128_cipher import rra_pkg::*; #(
   parameter int ROUND_COUNT = RoundCountDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   rra_req_if.sink   req,
   rra_rsp_if.source rsp,
   rra_csr_if.sink   csr
);
   localparam int SettleWidth = $clog2(ROUND_COUNT + 1);

   logic [HalfWidth-1:0]   key_high_ff, key_low_ff;
   logic [SettleWidth-1:0] settle_ff;
   block_type              rk [ROUND_COUNT+1];
   byte_type               rcon [ROUND_COUNT];
   stage_type              st [ROUND_COUNT+1];
   stage_type              head_ff;
   stage_type              head_in;
   logic                   advance;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_KEY_HIGH: key_high_ff <= csr.data;
            CSR_KEY_LOW:  key_low_ff  <= csr.data;
            default:      ;
         endcase
      end
   end

   // hold blocks off while the key chain settles
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '0;
      end else if (csr.valid) begin
         settle_ff <= SettleWidth'(ROUND_COUNT);
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - 1'b1;
      end
   end

   assign rk[0]   = {key_high_ff, key_low_ff};
   assign rcon[0] = 8'h01;
   for (genvar i = 1; i <= ROUND_COUNT; i++) begin : g_key
      if (i < ROUND_COUNT) begin : g_rcon
         assign rcon[i] = xtime(rcon[i-1]);
      end
      rra_key_cell u_key (
         .clock(clock), .reset(reset), .rcon(rcon[i-1]),
         .prev_key(rk[i-1]), .key(rk[i])
      );
   end

   // advance when the last register is empty or drained
   assign advance   = !st[ROUND_COUNT].valid || rsp.ready;
   assign req.ready = advance && !csr.valid && (settle_ff == '0);

   always_comb begin
      head_in.valid = req.valid && req.ready;
      head_in.op    = req.op;
      head_in.data  = {req.block_high, req.block_low}
                      ^ (req.op ? rk[ROUND_COUNT] : rk[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff.valid <= head_in.valid;
      end
      if (advance) begin
         head_ff.op   <= head_in.op;
         head_ff.data <= head_in.data;
      end
   end

   assign st[0] = head_ff;

   // decrypt cell i > 1 uses key ROUND_COUNT-i+1; key 0 is added at the result output
   for (genvar i = 1; i <= ROUND_COUNT; i++) begin : g_round
      stage_type cell_out;
      rra_round_cell #(.FIRST(i == 1), .LAST(i == ROUND_COUNT)) u_round (
         .clock(clock), .reset(reset), .advance(advance),
         .stage_in(st[i-1]), .enc_key(rk[i]),
         .dec_key(i == 1 ? '0 : rk[ROUND_COUNT-i+1]),
         .stage_out(cell_out)
      );
      assign st[i] = cell_out;
   end

   assign rsp.valid       = st[ROUND_COUNT].valid;
   assign rsp.result_high = st[ROUND_COUNT].op
                            ? st[ROUND_COUNT].data[127:64] ^ rk[0][127:64]
                            : st[ROUND_COUNT].data[127:64];
   assign rsp.result_low  = st[ROUND_COUNT].op
                            ? st[ROUND_COUNT].data[63:0] ^ rk[0][63:0]
                            : st[ROUND_COUNT].data[63:0];

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(head_ff.data))
      else $error("pipeline moved while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req.ready |-> advance)
      else $error("input ready without pipeline advance");
endmodule
`default_nettype wire
